/* sv/tesb_pkg.sv */
// ----------------------------------------------------------------------------
// tesb_pkg
// Shared types and constants for the equal-split trajectory box extractor:
// input and result words, running bounds and the shared unit's operation codes.
// ----------------------------------------------------------------------------
package tesb_pkg;

  // clamps applied to the sequence length and the box target
  localparam int unsigned MAX_INSTANTS = 65535;
  localparam int unsigned MAX_BOXES    = 1000;
  localparam int unsigned BOXES_RESET  = 10;

  // register map: register index taken from paddr[2]
  localparam logic REG_BOXES_WANTED = 1'b0;

  // one trajectory instant
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [63:0] stamp;
    logic        [15:0] seq_length;
  } in_word_t;

  // one bounding box
  typedef struct packed {
    logic signed [31:0] box_xmin;
    logic signed [31:0] box_xmax;
    logic signed [31:0] box_ymin;
    logic signed [31:0] box_ymax;
    logic signed [63:0] box_tmin;
    logic signed [63:0] box_tmax;
    logic        [9:0]  box_number;
    logic               last_box;
  } out_word_t;

  // running bounds of the open box
  typedef struct packed {
    logic signed [31:0] xmin;
    logic signed [31:0] xmax;
    logic signed [31:0] ymin;
    logic signed [31:0] ymax;
    logic signed [63:0] tmin;
    logic signed [63:0] tmax;
  } bounds_t;

  // operation of the shared compare unit
  typedef enum logic [2:0] {
    OP_XMIN = 3'd0,
    OP_XMAX = 3'd1,
    OP_YMIN = 3'd2,
    OP_YMAX = 3'd3,
    OP_TMIN = 3'd4,
    OP_TMAX = 3'd5,
    OP_DIV  = 3'd6
  } op_t;

endpackage

/* sv/tesb_cmp_unit.sv */
// ----------------------------------------------------------------------------
// tesb_cmp_unit
// Shared signed 64-bit less-than unit with operand selection: serves the six
// bound updates of an instant and each step of the group-size division.
// ----------------------------------------------------------------------------
module tesb_cmp_unit (
  input  tesb_pkg::op_t       op,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [63:0]  stamp,
  input  tesb_pkg::bounds_t   bnd,
  input  logic        [11:0]  div_rem,
  input  logic        [9:0]   div_den,
  output logic                lt
);

  logic signed [63:0] opa;
  logic signed [63:0] opb;

  // operand select: lt means the first operand is below the second
  always_comb begin
    unique case (op)
      tesb_pkg::OP_XMIN: begin
        opa = {{32{pos_x[31]}}, pos_x};
        opb = {{32{bnd.xmin[31]}}, bnd.xmin};
      end
      tesb_pkg::OP_XMAX: begin
        opa = {{32{bnd.xmax[31]}}, bnd.xmax};
        opb = {{32{pos_x[31]}}, pos_x};
      end
      tesb_pkg::OP_YMIN: begin
        opa = {{32{pos_y[31]}}, pos_y};
        opb = {{32{bnd.ymin[31]}}, bnd.ymin};
      end
      tesb_pkg::OP_YMAX: begin
        opa = {{32{bnd.ymax[31]}}, bnd.ymax};
        opb = {{32{pos_y[31]}}, pos_y};
      end
      tesb_pkg::OP_TMIN: begin
        opa = stamp;
        opb = bnd.tmin;
      end
      tesb_pkg::OP_TMAX: begin
        opa = bnd.tmax;
        opb = stamp;
      end
      default: begin
        // division step: partial remainder against the divisor
        opa = {52'd0, div_rem};
        opb = {54'd0, div_den};
      end
    endcase
  end

  assign lt = (opa < opb);

endmodule

/* sv/trajectory_equal_split_boxes.sv */
// ----------------------------------------------------------------------------
// trajectory_equal_split_boxes
// Splits the segments of a trajectory into equal groups and emits one
// spatio-temporal bounding box per group.
// ----------------------------------------------------------------------------
// usage
//   in channel : one instant per word (x, y, stamp, sequence length), valid/ready
//   out channel: one box word when a group closes, valid/ready, held in an
//                output register so the result waits without holding up input
//   cfg port   : APB-style, boxes_wanted at byte address 0, read back anytime
// sequencing
//   one shared 64-bit compare unit does all the work under a small sequencer;
//   in_ready is high only while the sequencer is idle
//   first instant of a sequence: an accept step, then 17 division steps for
//   the group size (one quotient bit per step), then back to idle
//   later instants: an accept step, then the xmin, xmax, ymin, ymax, tmin and
//   tmax compare steps, and an emit step when a box closes
//   a one-instant sequence goes from its accept step straight to the emit step
// reset and stall
//   rst_n (synchronous) clears the sequence counters and sets boxes_wanted to
//   10; if a box is ready while the output register still holds an untaken
//   box, the sequencer waits in its emit step until the receiver takes it
// ----------------------------------------------------------------------------
module trajectory_equal_split_boxes (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tesb_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tesb_pkg::out_word_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam logic [4:0] DIV_LAST = 5'd16;

  // control
  state_t        state_r, state_nxt;
  tesb_pkg::op_t op_r, op_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [15:0]   idx_r, idx_nxt;
  logic [15:0]   grp_r, grp_nxt;
  logic [15:0]   seg_r, seg_nxt;
  logic [9:0]    boxes_r, boxes_nxt;
  logic          last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [9:0]    bw_r, bw_nxt;

  // datapath
  logic signed [31:0]  x_r, x_nxt;
  logic signed [31:0]  y_r, y_nxt;
  logic signed [63:0]  t_r, t_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [9:0]          k_r, k_nxt;
  logic [16:0]         num_r, num_nxt;
  logic [10:0]         rem_r, rem_nxt;
  tesb_pkg::bounds_t   bnd_r, bnd_nxt;
  tesb_pkg::out_word_t out_r, out_nxt;

  logic        in_fire;
  logic        out_load;
  logic        cmp_lt;
  logic [11:0] rem_sh;
  logic [15:0] len_in;
  logic [9:0]  k_in;
  logic [15:0] seg_inc;
  logic [15:0] idx_inc;
  logic        close_last;
  logic        cfg_wr;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign rem_sh     = {rem_r, num_r[16]};
  assign seg_inc    = seg_r + 16'd1;
  assign idx_inc    = idx_r + 16'd1;
  assign close_last = (idx_inc == 16'd0) || (idx_inc >= len_r);

  // shared compare unit
  tesb_cmp_unit u_cmp (
    .op      (op_r),
    .pos_x   (x_r),
    .pos_y   (y_r),
    .stamp   (t_r),
    .bnd     (bnd_r),
    .div_rem (rem_sh),
    .div_den (k_r),
    .lt      (cmp_lt)
  );

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == tesb_pkg::REG_BOXES_WANTED) ? {22'd0, bw_r} : 32'd0;
  assign bw_nxt     = (cfg_wr && cfg_paddr[2] == tesb_pkg::REG_BOXES_WANTED)
                      ? cfg_pwdata[9:0] : bw_r;

  // clamp incoming length and box target
  always_comb begin
    len_in = in_data.seq_length;
    if (len_in == 16'd0) begin
      len_in = 16'd1;
    end
    if ({1'b0, len_in} > 17'(tesb_pkg::MAX_INSTANTS)) begin
      len_in = 16'(tesb_pkg::MAX_INSTANTS);
    end
    k_in = bw_r;
    if (k_in == 10'd0) begin
      k_in = 10'd1;
    end
    if (k_in > 10'(tesb_pkg::MAX_BOXES)) begin
      k_in = 10'(tesb_pkg::MAX_BOXES);
    end
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    grp_nxt   = grp_r;
    seg_nxt   = seg_r;
    boxes_nxt = boxes_r;
    last_nxt  = last_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    t_nxt     = t_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    bnd_nxt   = bnd_r;
    out_nxt   = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt   = in_data.pos_x;
          y_nxt   = in_data.pos_y;
          t_nxt   = in_data.stamp;
          len_nxt = len_in;
          if (idx_r == 16'd0) begin
            // sequence start: open the first box
            bnd_nxt.xmin = in_data.pos_x;
            bnd_nxt.xmax = in_data.pos_x;
            bnd_nxt.ymin = in_data.pos_y;
            bnd_nxt.ymax = in_data.pos_y;
            bnd_nxt.tmin = in_data.stamp;
            bnd_nxt.tmax = in_data.stamp;
            seg_nxt      = 16'd0;
            boxes_nxt    = 10'd0;
            if (len_in <= 16'd1) begin
              last_nxt  = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              k_nxt     = k_in;
              num_nxt   = 17'(len_in - 16'd1) + 17'(k_in - 10'd1);
              rem_nxt   = 11'd0;
              cnt_nxt   = 5'd0;
              op_nxt    = tesb_pkg::OP_DIV;
              state_nxt = S_DIV;
            end
          end else begin
            op_nxt    = tesb_pkg::OP_XMIN;
            state_nxt = S_CMP;
          end
        end
      end

      S_DIV: begin
        // restoring division, one quotient bit per step
        num_nxt = {num_r[15:0], !cmp_lt};
        rem_nxt = cmp_lt ? rem_sh[10:0] : 11'(rem_sh - {2'd0, k_r});
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          grp_nxt   = (num_nxt[15:0] == 16'd0) ? 16'd1 : num_nxt[15:0];
          idx_nxt   = 16'd1;
          state_nxt = S_IDLE;
        end
      end

      S_CMP: begin
        // widen one bound per cycle
        unique case (op_r)
          tesb_pkg::OP_XMIN: begin
            if (cmp_lt) bnd_nxt.xmin = x_r;
            op_nxt = tesb_pkg::OP_XMAX;
          end
          tesb_pkg::OP_XMAX: begin
            if (cmp_lt) bnd_nxt.xmax = x_r;
            op_nxt = tesb_pkg::OP_YMIN;
          end
          tesb_pkg::OP_YMIN: begin
            if (cmp_lt) bnd_nxt.ymin = y_r;
            op_nxt = tesb_pkg::OP_YMAX;
          end
          tesb_pkg::OP_YMAX: begin
            if (cmp_lt) bnd_nxt.ymax = y_r;
            op_nxt = tesb_pkg::OP_TMIN;
          end
          tesb_pkg::OP_TMIN: begin
            if (cmp_lt) bnd_nxt.tmin = t_r;
            op_nxt = tesb_pkg::OP_TMAX;
          end
          default: begin
            // last bound, then decide whether the group closes
            if (cmp_lt) bnd_nxt.tmax = t_r;
            seg_nxt  = seg_inc;
            idx_nxt  = idx_inc;
            last_nxt = close_last;
            if (close_last || seg_inc >= grp_r) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        endcase
      end

      S_EMIT: begin
        if (out_load) begin
          out_nxt.box_xmin   = bnd_r.xmin;
          out_nxt.box_xmax   = bnd_r.xmax;
          out_nxt.box_ymin   = bnd_r.ymin;
          out_nxt.box_ymax   = bnd_r.ymax;
          out_nxt.box_tmin   = bnd_r.tmin;
          out_nxt.box_tmax   = bnd_r.tmax;
          out_nxt.box_number = boxes_r;
          out_nxt.last_box   = last_r;
          seg_nxt            = 16'd0;
          if (last_r) begin
            idx_nxt   = 16'd0;
            boxes_nxt = 10'd0;
          end else begin
            // boundary instant opens the next box
            bnd_nxt.xmin = x_r;
            bnd_nxt.xmax = x_r;
            bnd_nxt.ymin = y_r;
            bnd_nxt.ymax = y_r;
            bnd_nxt.tmin = t_r;
            bnd_nxt.tmax = t_r;
            boxes_nxt    = boxes_r + 10'd1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= tesb_pkg::OP_XMIN;
      cnt_r       <= 5'd0;
      idx_r       <= 16'd0;
      grp_r       <= 16'd0;
      seg_r       <= 16'd0;
      boxes_r     <= 10'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bw_r        <= 10'(tesb_pkg::BOXES_RESET);
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      grp_r       <= grp_nxt;
      seg_r       <= seg_nxt;
      boxes_r     <= boxes_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      bw_r        <= bw_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    t_r   <= t_nxt;
    len_r <= len_nxt;
    k_r   <= k_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    bnd_r <= bnd_nxt;
    out_r <= out_nxt;
  end

  // a closed final box restarts the sequence
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> (idx_r == 16'd0 && boxes_r == 10'd0))
    else $error("sequence not restarted after final box");

  // mid-sequence the group size is known
  a_group_set: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 16'd0) |-> (grp_r != 16'd0))
    else $error("group size zero inside a sequence");

  // a non-final box advances the box count by one
  a_box_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !last_r) |=> (boxes_r == $past(boxes_r) + 10'd1))
    else $error("box count did not advance");

  // a box is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("waiting box overwritten");

endmodule

/* bench/tb_trajectory_equal_split_boxes.sv */
// ----------------------------------------------------------------------------
// tb_trajectory_equal_split_boxes
// Self-checking bench for the equal-split trajectory box extractor. A short
// table of directed instants (point boxes, extreme coordinates, box target
// clamps, length changes inside a sequence) is followed by random phases of
// trajectories under several box targets. Every box is compared field by
// field with a cycle-free grouping model, or the table's box for point rows.
// ----------------------------------------------------------------------------
module tb_trajectory_equal_split_boxes;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned   DRAIN_CYCLES   = 40;
  localparam int unsigned   WATCHDOG_LIMIT = 1000;
  localparam logic [2:0]    TARGET_ADDR    = {tesb_pkg::REG_BOXES_WANTED, 2'b00};
  localparam logic [31:0]   XY_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0]   XY_MIN         = 32'h8000_0000;
  localparam logic [63:0]   T_MAX          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]   T_MIN          = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {ROW_CFG, ROW_INSTANT, ROW_POINT} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [9:0]          target;
    tesb_pkg::in_word_t  w;
    tesb_pkg::out_word_t box;
  } stim_row_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  tesb_pkg::in_word_t  in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  tesb_pkg::out_word_t out_data;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [2:0]          cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // grouping state of the bench model
  logic [9:0]        box_target = 10'(tesb_pkg::BOXES_RESET);
  logic [15:0]       pos_in_seq = '0;
  logic [15:0]       grp_size   = '0;
  logic [15:0]       seg_count  = '0;
  logic [9:0]        box_count  = '0;
  tesb_pkg::bounds_t run_bounds = '0;

  tesb_pkg::out_word_t expected_boxes[$];
  stim_row_t           stim_rows[$];
  tesb_pkg::out_word_t pinned_box;
  bit                  pin_next   = 1'b0;
  bit                  idle_on    = 1'b1;
  int unsigned         mismatches = 0;

  trajectory_equal_split_boxes uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // start a new box on one instant
  function automatic void open_bounds(input tesb_pkg::in_word_t w);
    run_bounds.xmin = w.pos_x;
    run_bounds.xmax = w.pos_x;
    run_bounds.ymin = w.pos_y;
    run_bounds.ymax = w.pos_y;
    run_bounds.tmin = w.stamp;
    run_bounds.tmax = w.stamp;
  endfunction

  function automatic tesb_pkg::out_word_t close_bounds(input bit last_one);
    tesb_pkg::out_word_t b;
    b.box_xmin   = run_bounds.xmin;
    b.box_xmax   = run_bounds.xmax;
    b.box_ymin   = run_bounds.ymin;
    b.box_ymax   = run_bounds.ymax;
    b.box_tmin   = run_bounds.tmin;
    b.box_tmax   = run_bounds.tmax;
    b.box_number = box_count;
    b.last_box   = last_one;
    return b;
  endfunction

  // one instant through the grouping; made is set when a box closes
  function automatic void predict_instant(input tesb_pkg::in_word_t w, output bit made,
                                          output tesb_pkg::out_word_t box);
    int unsigned len;
    int unsigned k;
    bit          last_one;
    made = 1'b0;
    box  = '0;
    len  = 32'(w.seq_length);
    if (len < 1) len = 1;
    // first instant: fix the group size from the length and target
    if (pos_in_seq == 0) begin
      open_bounds(w);
      seg_count = '0;
      box_count = '0;
      if (len <= 1) begin
        made = 1'b1;
        box  = close_bounds(1'b1);
        return;
      end
      k = 32'(box_target);
      if (k < 1) k = 1;
      if (k > tesb_pkg::MAX_BOXES) k = tesb_pkg::MAX_BOXES;
      grp_size = 16'((len - 1 + k - 1) / k);
      if (grp_size == 0) grp_size = 16'd1;
      pos_in_seq = 16'd1;
      return;
    end
    // widen the running bounds
    if ($signed(w.pos_x) < $signed(run_bounds.xmin)) run_bounds.xmin = w.pos_x;
    if ($signed(w.pos_x) > $signed(run_bounds.xmax)) run_bounds.xmax = w.pos_x;
    if ($signed(w.pos_y) < $signed(run_bounds.ymin)) run_bounds.ymin = w.pos_y;
    if ($signed(w.pos_y) > $signed(run_bounds.ymax)) run_bounds.ymax = w.pos_y;
    if ($signed(w.stamp) < $signed(run_bounds.tmin)) run_bounds.tmin = w.stamp;
    if ($signed(w.stamp) > $signed(run_bounds.tmax)) run_bounds.tmax = w.stamp;
    seg_count  = seg_count + 16'd1;
    pos_in_seq = pos_in_seq + 16'd1;
    last_one   = (pos_in_seq == 0) || (pos_in_seq >= len);
    if (!last_one && seg_count < grp_size) return;
    made = 1'b1;
    box  = close_bounds(last_one);
    // boundary instant closes this box; unless it is the last, it opens the next
    if (last_one) begin
      pos_in_seq = '0;
      seg_count  = '0;
      box_count  = '0;
    end else begin
      open_bounds(w);
      seg_count = '0;
      box_count = box_count + 10'd1;
    end
  endfunction

  function automatic logic [31:0] rand_xy();
    case ($urandom_range(0, 7))
      0:       return XY_MAX;
      1:       return XY_MIN;
      2:       return 32'($signed($urandom_range(0, 511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  function automatic tesb_pkg::in_word_t rand_instant(input logic [15:0] len);
    tesb_pkg::in_word_t w;
    w.pos_x = rand_xy();
    w.pos_y = rand_xy();
    case ($urandom_range(0, 7))
      0:       w.stamp = T_MAX;
      1:       w.stamp = T_MIN;
      default: w.stamp = {$urandom, $urandom};
    endcase
    w.seq_length = len;
    return w;
  endfunction

  // directed table helpers
  function automatic void add_cfg(input logic [9:0] k);
    stim_row_t r;
    r.kind   = ROW_CFG;
    r.target = k;
    r.w      = '0;
    r.box    = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_instant(input logic [31:0] x, input logic [31:0] y,
                                      input logic [63:0] t, input logic [15:0] len,
                                      input bit point);
    stim_row_t r;
    r.kind   = point ? ROW_POINT : ROW_INSTANT;
    r.target = '0;
    r.w      = '{pos_x: x, pos_y: y, stamp: t, seq_length: len};
    r.box    = '{box_xmin: x, box_xmax: x, box_ymin: y, box_ymax: y,
                 box_tmin: t, box_tmax: t, box_number: 10'd0, last_box: 1'b1};
    stim_rows.push_back(r);
  endfunction

  // offer one word after a random gap when idle_on is set, then predict on acceptance
  task automatic send_instant(input tesb_pkg::in_word_t w);
    int unsigned         gap;
    bit                  made;
    tesb_pkg::out_word_t box;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_instant(w, made, box);
    if (pin_next) begin
      expected_boxes.push_back(pinned_box);
      pin_next = 1'b0;
    end else if (made) begin
      expected_boxes.push_back(box);
    end
  endtask

  // hold off input until every box is out and the block has settled
  task automatic drain_boxes();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_target();
    logic [31:0] rd;
    cfg_access(1'b0, TARGET_ADDR, '0, rd);
    if (rd[9:0] !== box_target)
      report_error($sformatf("boxes_wanted read %h want %h", rd[9:0], box_target));
  endtask

  task automatic set_box_target(input logic [9:0] k);
    logic [31:0] rd;
    cfg_access(1'b1, TARGET_ADDR, {22'd0, k}, rd);
    box_target = k;
    check_target();
  endtask

  // random trajectories under one box target, ending on a closed sequence
  task automatic run_random_phase(input logic [9:0] k, input int unsigned quota);
    int unsigned sent;
    int unsigned seq_len;
    int unsigned n;
    int unsigned pick;
    set_box_target(k);
    sent = 0;
    while (sent < quota) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 9);
      if (pick == 0) begin
        // point box, length zero or one
        send_instant(rand_instant(16'($urandom_range(0, 1))));
        sent++;
      end else if (pick == 1) begin
        // sequence cut short by a smaller length
        seq_len = $urandom_range(2, 60);
        n       = $urandom_range(1, seq_len);
        repeat (n) send_instant(rand_instant(16'(seq_len)));
        send_instant(rand_instant(16'($urandom_range(0, n))));
        sent += n + 1;
      end else begin
        seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 120)
                                              : $urandom_range(2, 40);
        repeat (seq_len) send_instant(rand_instant(16'(seq_len)));
        sent += seq_len;
      end
    end
    if (pos_in_seq != 0) send_instant(rand_instant(16'd1));
    drain_boxes();
  endtask

  // result side: random stall while idle_on is set, then compare with the oldest expectation
  initial begin : receive_boxes
    int unsigned         stall;
    tesb_pkg::out_word_t want;
    tesb_pkg::out_word_t got;
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_valid === 1'b1));
      got = out_data;
      if (expected_boxes.size() == 0) begin
        report_error($sformatf("unexpected box %0d", got.box_number));
      end else begin
        want = expected_boxes.pop_front();
        if (got.box_xmin !== want.box_xmin)
          report_error($sformatf("xmin got %h want %h", got.box_xmin, want.box_xmin));
        if (got.box_xmax !== want.box_xmax)
          report_error($sformatf("xmax got %h want %h", got.box_xmax, want.box_xmax));
        if (got.box_ymin !== want.box_ymin)
          report_error($sformatf("ymin got %h want %h", got.box_ymin, want.box_ymin));
        if (got.box_ymax !== want.box_ymax)
          report_error($sformatf("ymax got %h want %h", got.box_ymax, want.box_ymax));
        if (got.box_tmin !== want.box_tmin)
          report_error($sformatf("tmin got %h want %h", got.box_tmin, want.box_tmin));
        if (got.box_tmax !== want.box_tmax)
          report_error($sformatf("tmax got %h want %h", got.box_tmax, want.box_tmax));
        if (got.box_number !== want.box_number)
          report_error($sformatf("box_number got %0d want %0d", got.box_number,
                                 want.box_number));
        if (got.last_box !== want.last_box)
          report_error($sformatf("last_box got %b want %b on box %0d", got.last_box,
                                 want.last_box, want.box_number));
      end
    end
  end

  // watchdog on cycles without any accepted word or config access
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    logic [9:0] k_pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_target();

    // point boxes at the extremes, length one and length zero
    add_instant(XY_MAX, XY_MIN, T_MIN, 16'd1, 1'b1);
    add_instant(XY_MIN, XY_MAX, T_MAX, 16'd0, 1'b1);
    // reset target, one segment per group
    add_instant(XY_MIN, XY_MAX, T_MIN, 16'd3, 1'b0);
    add_instant(XY_MAX, XY_MIN, T_MAX, 16'd3, 1'b0);
    add_instant(32'd0, -32'sd1, 64'd0, 16'd3, 1'b0);
    // target zero acts as one: a single box over all instants
    add_cfg(10'd0);
    add_instant(32'd1, 32'd2, 64'd3, 16'd4, 1'b0);
    add_instant(XY_MAX, XY_MAX, T_MAX, 16'd4, 1'b0);
    add_instant(XY_MIN, XY_MIN, T_MIN, 16'd4, 1'b0);
    add_instant(-32'sd5, 32'd7, -64'sd9, 16'd4, 1'b0);
    // target above the limit, longest length cut short by a shorter one
    add_cfg(10'd1023);
    add_instant(XY_MAX, 32'd0, T_MAX, 16'hFFFF, 1'b0);
    add_instant(XY_MIN, XY_MAX, 64'd5, 16'hFFFF, 1'b0);
    add_instant(32'd9, XY_MIN, T_MIN, 16'hFFFF, 1'b0);
    add_instant(32'd0, 32'd0, 64'd0, 16'd2, 1'b0);
    // target one on the longest length, ended by a zero length
    add_cfg(10'd1);
    add_instant(32'd100, -32'sd100, 64'd10, 16'hFFFF, 1'b0);
    add_instant(-32'sd100, 32'd100, 64'd20, 16'hFFFF, 1'b0);
    add_instant(32'd50, 32'd50, 64'd15, 16'd0, 1'b0);
    // top target, one box per segment
    add_cfg(10'd1000);
    add_instant(XY_MIN, XY_MIN, T_MIN, 16'd5, 1'b0);
    add_instant(XY_MAX, XY_MAX, T_MAX, 16'd5, 1'b0);
    add_instant(XY_MIN, XY_MAX, T_MIN, 16'd5, 1'b0);
    add_instant(XY_MAX, XY_MIN, T_MAX, 16'd5, 1'b0);
    add_instant(32'd0, 32'd0, 64'd0, 16'd5, 1'b0);

    idle_on = 1'b1;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_boxes();
        set_box_target(stim_rows[i].target);
      end else begin
        pin_next   = (stim_rows[i].kind == ROW_POINT);
        pinned_box = stim_rows[i].box;
        send_instant(stim_rows[i].w);
      end
    end
    drain_boxes();

    // random phases over a spread of targets
    run_random_phase(10'd1, 55);
    run_random_phase(10'd1000, 55);
    run_random_phase(10'd0, 55);
    run_random_phase(10'd1023, 55);
    k_pick = 10'($urandom_range(2, 9));
    run_random_phase(k_pick, 55);
    k_pick = 10'($urandom_range(11, 999));
    run_random_phase(k_pick, 55);
    run_random_phase(10'(tesb_pkg::BOXES_RESET), 55);

    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* trajectory_equal_split_boxes.f */
sv/tesb_pkg.sv
sv/tesb_cmp_unit.sv
sv/trajectory_equal_split_boxes.sv
bench/tb_trajectory_equal_split_boxes.sv
